### hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
// No dependencies; used by every other file in hw/rtl.
`default_nettype none
package bpc_pkg;

    localparam int unsigned DivStages = 32;

    typedef enum logic [2:0] {
        REG_AC1_AC2_AC3 = 3'd0,
        REG_AC4_AC5_AC6 = 3'd1,
        REG_B1_B2       = 3'd2,
        REG_MC_MD       = 3'd3,
        REG_OSS         = 3'd4
    } t_cfg_idx;

    // calibration, already extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    // sideband carried through a divider pipe
    typedef struct packed {
        logic        err;
        logic        neg;
        logic        dbl;
        logic [31:0] x1;
        logic [23:0] up;
    } t_side;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'd7357;
    localparam logic [31:0] C_P_K3     = 32'd3791;

endpackage
`default_nettype wire

### hw/rtl/bpc_cfg_regs.sv
// Calibration and oversampling registers with field extraction.
// Depends on bpc_pkg.
`default_nettype none
module bpc_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    output bpc_pkg::t_cal      o_cal
);
    logic [47:0] r_ac123;
    logic [47:0] r_ac456;
    logic [31:0] r_b12;
    logic [31:0] r_mcmd;
    logic [1:0]  r_oss;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12   <= '0;
            r_mcmd  <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpc_pkg::REG_AC1_AC2_AC3: r_ac123 <= i_cfg_data;
                bpc_pkg::REG_AC4_AC5_AC6: r_ac456 <= i_cfg_data;
                bpc_pkg::REG_B1_B2:       r_b12   <= i_cfg_data[31:0];
                bpc_pkg::REG_MC_MD:       r_mcmd  <= i_cfg_data[31:0];
                bpc_pkg::REG_OSS:         r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cal.ac1 = {{16{r_ac123[47]}}, r_ac123[47:32]};
        o_cal.ac2 = {{16{r_ac123[31]}}, r_ac123[31:16]};
        o_cal.ac3 = {{16{r_ac123[15]}}, r_ac123[15:0]};
        o_cal.ac4 = {16'd0, r_ac456[47:32]};
        o_cal.ac5 = {16'd0, r_ac456[31:16]};
        o_cal.ac6 = {16'd0, r_ac456[15:0]};
        o_cal.b1  = {{16{r_b12[31]}}, r_b12[31:16]};
        o_cal.b2  = {{16{r_b12[15]}}, r_b12[15:0]};
        o_cal.mc  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
        o_cal.md  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};
        o_cal.oss = r_oss;
    end
endmodule
`default_nettype wire

### hw/rtl/bpc_udiv_pipe.sv
// Pipelined 32/32 unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg (stage count, sideband type).
`default_nettype none
module bpc_udiv_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [31:0]    i_dividend,
    input  wire logic [31:0]    i_divisor,
    input  bpc_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [31:0]         o_quot,
    output bpc_pkg::t_side      o_side
);
    localparam int unsigned N = bpc_pkg::DivStages;

    logic [N-1:0]       r_v;
    logic [31:0]        r_rem  [N];
    logic [31:0]        r_q    [N];
    logic [31:0]        r_dv   [N];
    bpc_pkg::t_side     r_side [N];

    logic [31:0]        n_rem  [N];
    logic [31:0]        n_q    [N];

    always_comb begin
        logic [31:0] rem_in;
        logic [31:0] q_in;
        logic [31:0] dv_in;
        logic [32:0] sh;
        for (int k = 0; k < N; k++) begin
            rem_in = (k == 0) ? 32'd0 : r_rem[(k == 0) ? 0 : k - 1];
            q_in   = (k == 0) ? i_dividend : r_q[(k == 0) ? 0 : k - 1];
            dv_in  = (k == 0) ? i_divisor : r_dv[(k == 0) ? 0 : k - 1];
            sh     = {rem_in, q_in[31]};
            if (sh >= {1'b0, dv_in}) begin
                n_rem[k] = 32'(sh - {1'b0, dv_in});
                n_q[k]   = {q_in[30:0], 1'b1};
            end else begin
                n_rem[k] = sh[31:0];
                n_q[k]   = {q_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_dv[k]   <= (k == 0) ? i_divisor : r_dv[(k == 0) ? 0 : k - 1];
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quot  = r_q[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

### hw/rtl/baro_pressure_compensation_unit.sv
// Barometric pressure compensation, top level. Uses bpc_pkg, bpc_cfg_regs and
// bpc_udiv_pipe.
//
// Takes one raw sample per transfer (two temperature bytes, three pressure
// bytes) and returns the compensated pressure in pascals, with a divide error
// flag in tuser (pressure then 0). Fully pipelined: a new sample can be taken
// every cycle while the output is not stalled; there are 75 register stages
// (10 arithmetic stages, two 32-stage bit-per-cycle dividers, one for the B5
// temperature quotient and one for the pressure quotient, and the output
// register). Back pressure stalls the whole pipe in place, so s_tready
// follows m_tready whenever the output register is full.
// Write the calibration registers only while the pipe is empty.
`default_nettype none
module baro_pressure_compensation_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // [7:0] temp_high_byte, [15:8] temp_low_byte, [23:16] press_high_byte,
    // [31:24] press_mid_byte, [39:32] press_extra_byte
    input  wire logic [39:0]    i_s_tdata,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    // [31:0] pressure_pa
    output logic [31:0]         o_m_tdata,
    // [0] divide_error
    output logic [0:0]          o_m_tuser,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [47:0]    i_cfg_data
);
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    bpc_pkg::t_cal cal;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (cal)
    );

    // whole pipe advances together; stalls only on a full, untaken output
    logic en;
    logic r_out_v;
    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en;

    // stage A: assemble UT - ac6 and UP
    logic        r_a_v;
    logic [31:0] r_a_d;
    logic [23:0] r_a_up;
    logic [23:0] raw_p;
    assign raw_p = {i_s_tdata[23:16], i_s_tdata[31:24], i_s_tdata[39:32]};

    // stage B: x1 from temperature
    logic        r_b_v;
    logic [31:0] r_b_x1;
    logic [23:0] r_b_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_tvalid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_d  <= {16'd0, i_s_tdata[7:0], i_s_tdata[15:8]} - cal.ac6;
            r_a_up <= raw_p >> (4'd8 - {2'b00, cal.oss});
            r_b_x1 <= asr(mul_lo(r_a_d, cal.ac5), 5'd15);
            r_b_up <= r_a_up;
        end
    end

    // signed divide (mc << 11) / (x1 + md) through magnitudes
    logic [31:0] d1_num, d1_den, d1_na, d1_da;
    logic        d1_zero;
    bpc_pkg::t_side d1_side_in, d1_side_out;
    logic        d1_ov;
    logic [31:0] d1_q;

    always_comb begin
        d1_num  = cal.mc << 11;
        d1_den  = r_b_x1 + cal.md;
        d1_zero = (d1_den == 32'd0);
        d1_na   = d1_num[31] ? 32'(-d1_num) : d1_num;
        d1_da   = d1_zero ? 32'd1 : (d1_den[31] ? 32'(-d1_den) : d1_den);
        d1_side_in.err = d1_zero;
        d1_side_in.neg = d1_num[31] ^ d1_den[31];
        d1_side_in.dbl = 1'b0;
        d1_side_in.x1  = r_b_x1;
        d1_side_in.up  = r_b_up;
    end

    bpc_udiv_pipe u_div_b5 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_b_v),
        .i_dividend (d1_na),
        .i_divisor  (d1_da),
        .i_side     (d1_side_in),
        .o_valid    (d1_ov),
        .o_quot     (d1_q),
        .o_side     (d1_side_out)
    );

    // stages D..I: B6, B3, B4, B7
    logic        r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_i_v;
    logic        r_d_err, r_e_err, r_f_err, r_g_err, r_h_err, r_i_err;
    logic [23:0] r_d_up, r_e_up, r_f_up, r_g_up;
    logic [31:0] r_d_b6;
    logic [31:0] r_e_bsq, r_e_m2, r_e_m3;
    logic [31:0] r_f_x1b, r_f_x2b, r_f_m2, r_f_m3;
    logic [31:0] r_g_b3, r_g_x3b;
    logic [31:0] r_h_b4, r_h_t;
    logic [31:0] r_i_b7, r_i_b4;

    logic [31:0] x2_b5, g_x3, g_v, g_b3;
    always_comb begin
        x2_b5 = d1_side_out.neg ? 32'(-d1_q) : d1_q;
        g_x3  = r_f_x1b + r_f_m2;
        g_v   = ((mul_lo(cal.ac1, 32'd4) + g_x3) << cal.oss) + 32'd2;
        // truncate toward zero
        g_b3  = asr(g_v + (g_v[31] ? 32'd3 : 32'd0), 5'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_i_v} <= '0;
        end else if (en) begin
            r_d_v <= d1_ov;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_err <= d1_side_out.err;
            r_d_up  <= d1_side_out.up;
            r_d_b6  <= d1_side_out.x1 + x2_b5 - bpc_pkg::C_B6_OFS;

            r_e_err <= r_d_err;
            r_e_up  <= r_d_up;
            r_e_bsq <= asr(mul_lo(r_d_b6, r_d_b6), 5'd12);
            r_e_m2  <= asr(mul_lo(cal.ac2, r_d_b6), 5'd11);
            r_e_m3  <= asr(mul_lo(cal.ac3, r_d_b6), 5'd13);

            r_f_err <= r_e_err;
            r_f_up  <= r_e_up;
            r_f_x1b <= asr(mul_lo(cal.b2, r_e_bsq), 5'd11);
            r_f_x2b <= asr(mul_lo(cal.b1, r_e_bsq), 5'd16);
            r_f_m2  <= r_e_m2;
            r_f_m3  <= r_e_m3;

            r_g_err <= r_f_err;
            r_g_up  <= r_f_up;
            r_g_b3  <= g_b3;
            r_g_x3b <= asr(r_f_m3 + r_f_x2b + 32'd2, 5'd2);

            r_h_err <= r_g_err;
            r_h_b4  <= mul_lo(cal.ac4, r_g_x3b + bpc_pkg::C_B4_OFS) >> 15;
            r_h_t   <= {8'd0, r_g_up} - r_g_b3;

            r_i_err <= r_h_err;
            r_i_b4  <= r_h_b4;
            r_i_b7  <= mul_lo(r_h_t, bpc_pkg::C_B7_SCALE >> cal.oss);
        end
    end

    // unsigned pressure quotient; doubling done before or after by B7 range
    logic [31:0] d2_num, d2_den;
    bpc_pkg::t_side d2_side_in, d2_side_out;
    logic        d2_ov;
    logic [31:0] d2_q;

    always_comb begin
        d2_side_in.dbl = !r_i_b7[31];
        d2_side_in.err = r_i_err || (r_i_b4 == 32'd0);
        d2_side_in.neg = 1'b0;
        d2_side_in.x1  = '0;
        d2_side_in.up  = '0;
        d2_num = r_i_b7[31] ? r_i_b7 : {r_i_b7[30:0], 1'b0};
        d2_den = (r_i_b4 == 32'd0) ? 32'd1 : r_i_b4;
    end

    bpc_udiv_pipe u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_i_v),
        .i_dividend (d2_num),
        .i_divisor  (d2_den),
        .i_side     (d2_side_in),
        .o_valid    (d2_ov),
        .o_quot     (d2_q),
        .o_side     (d2_side_out)
    );

    // stages J, K and output: second-order correction
    logic        r_j_v, r_k_v;
    logic        r_j_err, r_k_err;
    logic [31:0] r_j_p, r_j_hp2, r_j_m7;
    logic [31:0] r_k_p, r_k_x1, r_k_x2;
    logic [31:0] r_out_p;
    logic        r_out_err;
    logic [31:0] j_p, j_hp;

    always_comb begin
        j_p  = d2_side_out.dbl ? d2_q : {d2_q[30:0], 1'b0};
        j_hp = asr(j_p, 5'd8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v   <= 1'b0;
            r_k_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_j_v   <= d2_ov;
            r_k_v   <= r_j_v;
            r_out_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_err <= d2_side_out.err;
            r_j_p   <= j_p;
            r_j_hp2 <= mul_lo(j_hp, j_hp);
            r_j_m7  <= mul_lo(bpc_pkg::C_P_K2, j_p);

            r_k_err <= r_j_err;
            r_k_p   <= r_j_p;
            r_k_x1  <= asr(mul_lo(r_j_hp2, bpc_pkg::C_P_K1), 5'd16);
            r_k_x2  <= asr(32'(-r_j_m7), 5'd16);

            r_out_err <= r_k_err;
            r_out_p   <= r_k_err ? 32'd0
                       : r_k_p + asr(r_k_x1 + r_k_x2 + bpc_pkg::C_P_K3, 5'd4);
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_p;
    assign o_m_tuser[0] = r_out_err;
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for baro_pressure_compensation_unit.
// Depends on bpc_pkg and the RTL under hw/rtl; computes expected pressure per sample.
`timescale 1ns / 1ps
module tb_top;

    localparam int PipeLatency = 75;

    typedef struct packed {
        logic [31:0] pressure;
        logic        div_err;
    } t_press_res;

    logic        i_clk;
    logic        i_rst_n;
    logic [39:0] i_s_tdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    baro_pressure_compensation_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(i_s_tdata), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow calibration
    logic [47:0] cal_ac;
    logic [47:0] cal_acu;
    logic [31:0] cal_b;
    logic [31:0] cal_m;
    logic [1:0]  cal_oss;

    t_press_res  press_expected[$];
    int          mismatch_cnt;
    int          result_cnt;
    int          err_cnt;
    bit          hold_off;
    int          hold_cycles;
    bit          rx_stall_en;
    int          rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    // signed truncating divide with -2^31/-1 wrap
    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
        longint qa;
        longint qb;
        qa = $signed(a);
        qb = $signed(b);
        return 32'(qa / qb);
    endfunction

    function automatic t_press_res compensate(logic [39:0] d);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b5, b6, b3, b4, b7, bsq, p;
        t_press_res r;
        ac1 = sx16(cal_ac[47:32]); ac2 = sx16(cal_ac[31:16]); ac3 = sx16(cal_ac[15:0]);
        ac4 = {16'd0, cal_acu[47:32]}; ac5 = {16'd0, cal_acu[31:16]};
        ac6 = {16'd0, cal_acu[15:0]};
        b1 = sx16(cal_b[31:16]); b2 = sx16(cal_b[15:0]);
        mc = sx16(cal_m[31:16]); md = sx16(cal_m[15:0]);
        ut = {16'd0, d[7:0], d[15:8]};
        up = {8'd0, d[23:16], d[31:24], d[39:32]} >> (8 - cal_oss);
        r = '0;
        x1 = sra((ut - ac6) * ac5, 15);
        if (x1 + md == 0) begin
            r.div_err = 1'b1;
            return r;
        end
        x2 = sdiv(mc << 11, x1 + md);
        b5 = x1 + x2;
        b6 = b5 - 32'd4000;
        bsq = sra(b6 * b6, 12);
        x1 = sra(b2 * bsq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdiv(((ac1 * 4 + x3) << cal_oss) + 2, 32'd4);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * bsq, 16);
        x3 = sra(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) begin
            r.div_err = 1'b1;
            return r;
        end
        b7 = (up - b3) * (32'd50000 >> cal_oss);
        if (!b7[31])
            p = (b7 * 2) / b4;
        else
            p = (b7 / b4) * 2;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(32'd0 - 32'd7357 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        r.pressure = p;
        return r;
    endfunction

    // random receiver stalls, mostly short with an occasional long one,
    // plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else if (rx_stall_en) begin
            if (rx_gap > 0) begin
                rx_gap     <= rx_gap - 1;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 40) == 0) begin
                rx_gap     <= $urandom_range(10, 40);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_press_res exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_cnt++;
            if (press_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result p=%0d err=%0b", $signed(o_m_tdata), o_m_tuser);
            end else begin
                exp_r = press_expected.pop_front();
                if (o_m_tdata !== exp_r.pressure || o_m_tuser[0] !== exp_r.div_err) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected p=%0d err=%0b, got p=%0d err=%0b",
                                 $signed(exp_r.pressure), exp_r.div_err,
                                 $signed(o_m_tdata), o_m_tuser[0]);
                end
                if (exp_r.div_err)
                    err_cnt++;
            end
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_off <= 1'b0;
        end
    end

    // tvalid stays high between back-to-back samples; dropped on a gap or a drain
    task automatic send_sample(logic [39:0] d, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= d;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        press_expected.push_back(compensate(d));
    endtask

    task automatic write_reg(bpc_pkg::t_cfg_idx idx, logic [47:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            bpc_pkg::REG_AC1_AC2_AC3: cal_ac  = val;
            bpc_pkg::REG_AC4_AC5_AC6: cal_acu = val;
            bpc_pkg::REG_B1_B2:       cal_b   = val[31:0];
            bpc_pkg::REG_MC_MD:       cal_m   = val[31:0];
            bpc_pkg::REG_OSS:         cal_oss = val[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        while (press_expected.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PipeLatency + 5) @(posedge i_clk);
    endtask

    // typical datasheet-like calibration
    task automatic load_typical_cal(logic [1:0] oss);
        write_reg(bpc_pkg::REG_AC1_AC2_AC3, {16'd408, -16'sd72, -16'sd14383});
        write_reg(bpc_pkg::REG_AC4_AC5_AC6, {16'd32741, 16'd32757, 16'd23153});
        write_reg(bpc_pkg::REG_B1_B2, {16'd0, 16'd6190, 16'd4});
        write_reg(bpc_pkg::REG_MC_MD, {16'd0, -16'sd8711, 16'd2868});
        write_reg(bpc_pkg::REG_OSS, {46'd0, oss});
    endtask

    task automatic test_directed();
        load_typical_cal(2'd0);
        send_sample({8'h00, 8'h00, 8'h5D, 8'hC8, 8'h6C}, 0);
        send_sample(40'd0, 0);
        send_sample({40{1'b1}}, 0);
        send_sample({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 0);
        send_sample({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 0);
        drain_pipe();
        write_reg(bpc_pkg::REG_OSS, 48'd3);
        send_sample({8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE}, 0);
        send_sample({40{1'b1}}, 0);
        drain_pipe();
        // zero temperature divisor: ac5=0 gives x1=0, md=0
        write_reg(bpc_pkg::REG_AC4_AC5_AC6, {16'd32741, 16'd0, 16'd23153});
        write_reg(bpc_pkg::REG_MC_MD, {16'd0, -16'sd8711, 16'd0});
        send_sample({8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}, 0);
        drain_pipe();
        // zero B4: ac4 = 0; md nonzero
        write_reg(bpc_pkg::REG_AC4_AC5_AC6, 48'd0);
        write_reg(bpc_pkg::REG_MC_MD, {16'd0, 16'h8000, 16'hFFFF});
        send_sample({8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}, 0);
        drain_pipe();
        // quotient overflow: mc<<11 = -2^31 needs mc=-2^20, not reachable; use extremes
        write_reg(bpc_pkg::REG_AC1_AC2_AC3, {48{1'b1}});
        write_reg(bpc_pkg::REG_AC4_AC5_AC6, {48{1'b1}});
        write_reg(bpc_pkg::REG_B1_B2, {48{1'b1}});
        write_reg(bpc_pkg::REG_MC_MD, {16'hFFFF, 16'h7FFF, 16'h8000});
        send_sample(40'd0, 0);
        send_sample({40{1'b1}}, 0);
        drain_pipe();
        write_reg(bpc_pkg::REG_OSS, {48{1'b1}});
        send_sample({8'h80, 8'h00, 8'h80, 8'h00, 8'h80}, 0);
        drain_pipe();
        write_reg(bpc_pkg::REG_B1_B2, {16'h8000, 16'h8000, 16'h7FFF});
        send_sample({8'h80, 8'h00, 8'h80, 8'h00, 8'h80}, 0);
        drain_pipe();
    endtask

    task automatic test_random_cal(int n_phases, int per_phase);
        for (int ph = 0; ph < n_phases; ph++) begin
            drain_pipe();
            if (ph % 3 == 0)
                load_typical_cal(2'($urandom_range(0, 3)));
            else begin
                write_reg(bpc_pkg::REG_AC1_AC2_AC3, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_AC4_AC5_AC6, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_B1_B2, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_MC_MD, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_OSS, 48'({$urandom, $urandom}));
            end
            rx_stall_en = (ph % 2 == 1);
            for (int i = 0; i < per_phase; i++)
                send_sample(40'({$urandom, $urandom}), ph % 4 != 0);
        end
        drain_pipe();
    endtask

    task automatic test_backpressure();
        load_typical_cal(2'd1);
        rx_stall_en = 1'b0;
        hold_off    <= 1'b1;
        hold_cycles <= 300;
        for (int i = 0; i < 150; i++)
            send_sample(40'({$urandom, $urandom}), 0);
        drain_pipe();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tdata   = '0;
        i_s_tvalid  = 1'b0;
        i_m_tready  = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_off    = 1'b0;
        hold_cycles = 0;
        rx_stall_en = 1'b0;
        rx_gap      = 0;
        mismatch_cnt = 0;
        result_cnt  = 0;
        err_cnt     = 0;
        cal_ac = '0; cal_acu = '0; cal_b = '0; cal_m = '0; cal_oss = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_cal(16, 85);

        $display("covered %0d samples, %0d with divide error, over 16 calibration sets",
                 result_cnt, err_cnt);
        if (mismatch_cnt == 0 && press_expected.size() == 0)
            $display("tb_top OK");
        else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     press_expected.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
